### hw/rtl/rar_pkg.sv
package rar_pkg;

  localparam int OperandWidthDef = 16;
  localparam int ResNumW = 33;
  localparam int ResDenW = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_PREP,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } state_t;

endpackage

### hw/rtl/rar_divider.sv
// restoring unsigned divider, one quotient bit a cycle
module rar_divider #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;

  assign trial    = {rem, quo[W-1]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], quo[W-1]};
          quo <= {quo[W-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### hw/rtl/rational_arith_reduce.sv
// Fraction arithmetic with reduction to lowest terms.
// Input beat on s_axis: op and four signed operands. Output beat on m_axis:
// reduced numerator and denominator, denominator non-negative unless the raw
// denominator is zero (then num/0 raw).
// One item at a time: s_axis_tready is high only while idle. An item passes
// through three multiply states (MUL0..MUL2) on one shared W by W multiplier
// and a prep state, a binary gcd, then two passes of a shared 64-bit
// bit-serial divider (numerator, then denominator). When the raw
// denominator is zero, prep goes straight to the output state.
// The result is held in an output register until m_axis_tready is high;
// nothing new is accepted meanwhile. The next input beat can be taken in the
// cycle after the result beat. Synchronous reset returns to idle with
// no result pending.
module rational_arith_reduce #(
  parameter int OPERAND_WIDTH = rar_pkg::OperandWidthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // a_num, a_den, b_num, b_den from bit 0 up (4*OPERAND_WIDTH bits)
  input  logic [4*OPERAND_WIDTH-1:0] s_axis_tdata,
  // req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // res_num [32:0], res_den [64:33], zero fill above
  output logic [71:0] m_axis_tdata
);
  import rar_pkg::*;

  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW + 2;   // raw values in signed
  localparam int DW = 64;

  state_t state, state_next;

  logic signed [OW-1:0] an, ad, bn, bd;
  op_t                  op;
  logic signed [PW-1:0] num, den, p0;
  logic [PW-1:0]        ga, gb;
  logic [6:0]           shft;
  logic [PW-1:0]        gval;
  logic signed [PW-1:0] rn, rd;

  logic signed [OW-1:0]   mx, my;
  logic signed [2*OW-1:0] prod;

  logic          dstart, ddone;
  logic [DW-1:0] ddvd, ddvs, dquo;

  logic [PW-1:0] mnum, mden;
  assign mnum = num[PW-1] ? -num : num;
  assign mden = den[PW-1] ? -den : den;

  assign prod = mx * my;

  always_comb begin
    mx = an;
    my = bd;
    case (state)
      ST_MUL0: begin mx = (op == OP_MUL) ? an : an; my = (op == OP_MUL) ? bn : bd; end
      ST_MUL1: begin mx = ad; my = (op == OP_DIV) ? bn : bd; end
      ST_MUL2: begin mx = ad; my = bn; end
      default: begin mx = an; my = bd; end
    endcase
  end

  rar_divider #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(dstart),
    .dividend(ddvd), .divisor(ddvs),
    .done(ddone), .quotient(dquo)
  );

  assign dstart = ((state == ST_GCD) && (gb == '0)) || ((state == ST_DIVN) && ddone);
  assign ddvs   = DW'(gval);
  assign ddvd   = (state == ST_GCD) ? DW'(mnum) : DW'(mden);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_MUL0;
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_PREP;
      ST_PREP: state_next = (den == '0) ? ST_OUT : ST_GCD;
      ST_GCD:  if (gb == '0) state_next = ST_DIVN;
      ST_DIVN: if (ddone) state_next = ST_DIVD;
      ST_DIVD: if (ddone) state_next = ST_OUT;
      ST_OUT:  if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_OUT);
  end

  assign gval = ga << shft;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;

    unique case (state)
      ST_IDLE: if (s_axis_tvalid) begin
        an <= s_axis_tdata[OW-1:0];
        ad <= s_axis_tdata[2*OW-1:OW];
        bn <= s_axis_tdata[3*OW-1:2*OW];
        bd <= s_axis_tdata[4*OW-1:3*OW];
        op <= op_t'(s_axis_tuser);
      end
      ST_MUL0: p0 <= PW'(prod);
      ST_MUL1: begin
        den <= PW'(prod);
        if (op == OP_MUL || op == OP_DIV) num <= p0;
      end
      ST_MUL2: if (op == OP_ADD) num <= p0 + PW'(prod);
               else if (op == OP_SUB) num <= p0 - PW'(prod);
      ST_PREP: begin
        rn   <= num;
        rd   <= '0;
        shft <= '0;
        if (num == '0) begin
          // factor is den if positive, else 1: run gcd on (g, 0)
          ga <= den[PW-1] ? PW'(1) : den;
          gb <= '0;
        end else begin
          ga <= mnum;
          gb <= mden;
        end
      end
      ST_GCD: if (gb != '0) begin
        // binary gcd, one step a cycle
        if (!ga[0] && !gb[0]) begin
          ga <= ga >> 1; gb <= gb >> 1; shft <= shft + 7'd1;
        end else if (!ga[0]) ga <= ga >> 1;
        else if (!gb[0]) gb <= gb >> 1;
        else if (ga > gb) ga <= ga - gb;
        else gb <= gb - ga;
      end
      ST_DIVN: if (ddone) rn <= num[PW-1] ? -PW'(dquo) : PW'(dquo);
      ST_DIVD: if (ddone) begin
        // magnitude quotient; sign goes to the numerator
        rd <= PW'(dquo);
        if (den[PW-1]) rn <= -rn;
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {7'd0, 32'(rd), 33'(rn)};

  a_one_hot_hs: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_den_nonneg: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (den != '0) |-> !rd[PW-1]) else $error("negative denominator");
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVN) |-> (gval != '0)) else $error("zero common factor");
endmodule
